/* src/sqvt_pkg.sv */
package sqvt_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int CORNERS = 4;
	localparam int CNT_W = $clog2(CORNERS);
	localparam logic [CNT_W-1:0] CORNER_LAST = CNT_W'(CORNERS - 1);

	localparam int CS_W = 34;
	localparam logic signed [CS_W-1:0] ONE_Q30 = CS_W'(64'sd1073741824);
	localparam logic signed [CS_W-1:0] CORDIC_X0 = CS_W'(64'sd652032874);
	localparam logic signed [32:0] HALF_Q16 = 33'sd32768;
	localparam int OFF_W = 50;

	localparam logic [1:0] CFG_PROJ_X = 2'd0;
	localparam logic [1:0] CFG_PROJ_Y = 2'd1;

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] width;
		logic signed [31:0] height;
		logic signed [31:0] pivot_x;
		logic signed [31:0] pivot_y;
		logic        [15:0] angle;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
	} sprite_t;

	typedef struct packed {
		logic        [1:0]  corner;
		logic signed [31:0] device_x;
		logic signed [31:0] device_y;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0]      pos_x;
		logic signed [31:0]      pos_y;
		logic signed [31:0]      w;
		logic signed [31:0]      h;
		logic signed [31:0]      sc_x;
		logic signed [31:0]      sc_y;
		logic signed [OFF_W-1:0] off_x;
		logic signed [OFF_W-1:0] off_y;
	} side_t;

	typedef struct packed {
		side_t                  side;
		logic signed [CS_W-1:0] c;
		logic signed [CS_W-1:0] s;
		logic                   bypass;
	} quad_t;

	function automatic logic signed [31:0] atan_turn(input int i);
		logic signed [31:0] r;
		case (i)
			0: r = 32'sd536870912;
			1: r = 32'sd316933406;
			2: r = 32'sd167458907;
			3: r = 32'sd85004756;
			4: r = 32'sd42667331;
			5: r = 32'sd21354465;
			6: r = 32'sd10680862;
			7: r = 32'sd5340245;
			8: r = 32'sd2670163;
			9: r = 32'sd1335087;
			10: r = 32'sd667544;
			11: r = 32'sd333772;
			12: r = 32'sd166886;
			13: r = 32'sd83443;
			14: r = 32'sd41721;
			15: r = 32'sd20860;
			16: r = 32'sd10430;
			17: r = 32'sd5215;
			18: r = 32'sd2607;
			19: r = 32'sd1303;
			20: r = 32'sd651;
			21: r = 32'sd325;
			22: r = 32'sd162;
			23: r = 32'sd81;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		logic signed [31:0] r;
		if (v > 80'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -80'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* src/sqvt_cordic.sv */
module sqvt_cordic
	import sqvt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  logic [15:0]            ang,
	input  side_t                  side_in,
	output logic                   v_out,
	output quad_t                  q_out
);

	localparam int N = CORDIC_STAGES;

	logic                   v_s    [0:N];
	logic signed [CS_W-1:0] x_s    [0:N];
	logic signed [CS_W-1:0] y_s    [0:N];
	logic signed [32:0]     z_s    [0:N];
	logic                   flip_s [0:N];
	logic                   byp_s  [0:N];
	side_t                  side_s [0:N];

	logic        [15:0] ang_f;
	logic               flip_in;

	// Angles in the left half plane are turned by a half turn first.
	assign flip_in = (ang >= 16'h4000) && (ang < 16'hc000);
	assign ang_f = flip_in ? (ang ^ 16'h8000) : ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_X0;
			y_s[0] <= '0;
			z_s[0] <= 33'(signed'({ang_f, 16'h0000}));
			flip_s[0] <= flip_in;
			byp_s[0] <= (ang == 16'h0000);
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - 33'(atan_turn(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + 33'(atan_turn(i));
				end
				flip_s[i+1] <= flip_s[i];
				byp_s[i+1] <= byp_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_comb begin
		q_out.side = side_s[N];
		q_out.bypass = byp_s[N];
		if (byp_s[N]) begin
			q_out.c = ONE_Q30;
			q_out.s = '0;
		end else if (flip_s[N]) begin
			q_out.c = -x_s[N];
			q_out.s = -y_s[N];
		end else begin
			q_out.c = x_s[N];
			q_out.s = y_s[N];
		end
	end

	assign v_out = v_s[N];

endmodule

/* src/sqvt_corner.sv */
module sqvt_corner
	import sqvt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  quad_t              q_in,
	input  logic [CNT_W-1:0]   cnt,
	input  logic signed [31:0] proj_x,
	input  logic signed [31:0] proj_y,
	output logic               v_out,
	output vertex_t            vtx
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [31:0]     lx_s1, ly_s1;
	logic signed [CS_W-1:0] c_s1, s_s1;
	logic                   byp_s1, byp_s2;
	side_t                  sd_s1, sd_s2, sd_s3, sd_s4;
	logic [CNT_W-1:0]       k_s1, k_s2, k_s3, k_s4, k_s5, k_s6;

	logic signed [65:0] pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [31:0] lx_s2, ly_s2;
	logic signed [31:0] rx_s3, ry_s3;
	logic signed [63:0] mx_s4, my_s4;
	logic signed [31:0] tx_s5, ty_s5;
	logic signed [63:0] dx_s6, dy_s6;

	logic signed [50:0] ex, ey;
	logic signed [66:0] rxw, ryw;
	logic signed [32:0] ax, ay;

	// Corners 0 and 3 sit on the left, corners 0 and 1 at the bottom.
	always_comb begin
		logic signed [50:0] wx, hy;
		wx = 51'(q_in.side.w);
		hy = 51'(q_in.side.h);
		if (cnt == 2'd0 || cnt == 2'd3)
			wx = -wx;
		if (cnt == 2'd0 || cnt == 2'd1)
			hy = -hy;
		ex = (wx - 51'(q_in.side.off_x)) >>> 1;
		ey = (hy - 51'(q_in.side.off_y)) >>> 1;
	end

	assign rxw = (67'(pxc_s2) - 67'(pys_s2)) >>> 30;
	assign ryw = (67'(pxs_s2) + 67'(pyc_s2)) >>> 30;
	assign ax = 33'(sat32(80'(mx_s4 >>> 16))) + 33'(sd_s4.pos_x);
	assign ay = 33'(sat32(80'(my_s4 >>> 16))) + 33'(sd_s4.pos_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_out <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1 <= sat32(80'(ex));
			ly_s1 <= sat32(80'(ey));
			c_s1 <= q_in.c;
			s_s1 <= q_in.s;
			byp_s1 <= q_in.bypass;
			sd_s1 <= q_in.side;
			k_s1 <= cnt;

			pxc_s2 <= 66'(lx_s1) * 66'(c_s1);
			pys_s2 <= 66'(ly_s1) * 66'(s_s1);
			pxs_s2 <= 66'(lx_s1) * 66'(s_s1);
			pyc_s2 <= 66'(ly_s1) * 66'(c_s1);
			lx_s2 <= lx_s1;
			ly_s2 <= ly_s1;
			byp_s2 <= byp_s1;
			sd_s2 <= sd_s1;
			k_s2 <= k_s1;

			rx_s3 <= byp_s2 ? lx_s2 : sat32(80'(rxw));
			ry_s3 <= byp_s2 ? ly_s2 : sat32(80'(ryw));
			sd_s3 <= sd_s2;
			k_s3 <= k_s2;

			mx_s4 <= 64'(rx_s3) * 64'(sd_s3.sc_x);
			my_s4 <= 64'(ry_s3) * 64'(sd_s3.sc_y);
			sd_s4 <= sd_s3;
			k_s4 <= k_s3;

			tx_s5 <= sat32(80'(ax));
			ty_s5 <= sat32(80'(ay));
			k_s5 <= k_s4;

			dx_s6 <= 64'(tx_s5) * 64'(proj_x);
			dy_s6 <= 64'(ty_s5) * 64'(proj_y);
			k_s6 <= k_s5;

			vtx.corner <= k_s6;
			vtx.device_x <= sat32(80'(dx_s6 >>> 16));
			vtx.device_y <= sat32(80'(dy_s6 >>> 16));
			vtx.last <= (k_s6 == CORNER_LAST);
		end
	end

endmodule

/* src/sprite_quad_vertex_transform.sv */
// Sprite quad vertex transform.
// A sprite request on the sprite channel (valid/ready) yields four vertex
// requests on the vertex channel, corners bottom-left, bottom-right,
// top-right, top-left, with last set on the fourth one.
// The projection scale registers are written through cfg_we, cfg_index and
// cfg_data; the user is to write them only while the block is idle, as the
// block does not enforce it. Index 0 is x, index 1 is y. From acceptance to
// the first corner a sprite passes the input register, the CORDIC entry
// register and one CORDIC stage per iteration, the corner register, six
// stages of corner arithmetic and the output register. Throughput is one
// corner per cycle while the receiver does not stall; the corner sequencer
// holds each sprite for its four corners, taking the next at the last one.
// Reset clears every valid bit and sets both projection scales to 16384.0
// (0x40000000 in Q16.16). When the receiver stalls, the whole pipeline holds
// in place and the sprite channel drops ready; nothing is lost or repeated.
module sprite_quad_vertex_transform
	import sqvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sprite_valid,
	output logic        sprite_ready,
	input  sprite_t     sprite,
	output logic        vertex_valid,
	input  logic        vertex_ready,
	output vertex_t     vertex,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] proj_x_q, proj_y_q;

	logic        adv, en_f;
	logic        v_s1;
	side_t       side_s1;
	logic [15:0] ang_s1;

	logic        cord_v;
	quad_t       cord_q;

	logic             ser_v_q;
	quad_t            ser_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [65:0] offx, offy;

	assign adv = !vertex_valid || vertex_ready;
	assign en_f = adv && (!ser_v_q || cnt_q == CORNER_LAST);
	assign sprite_ready = en_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_x_q <= 32'sh40000000;
			proj_y_q <= 32'sh40000000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROJ_X: proj_x_q <= cfg_data;
				CFG_PROJ_Y: proj_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign offx = (66'(33'(sprite.pivot_x) - HALF_Q16)) * 66'(sprite.width);
	assign offy = (66'(33'(sprite.pivot_y) - HALF_Q16)) * 66'(sprite.height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_f) begin
			v_s1 <= sprite_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			side_s1.pos_x <= sprite.position_x;
			side_s1.pos_y <= sprite.position_y;
			side_s1.w <= sprite.width;
			side_s1.h <= sprite.height;
			side_s1.sc_x <= sprite.scale_x;
			side_s1.sc_y <= sprite.scale_y;
			side_s1.off_x <= offx[64:15];
			side_s1.off_y <= offy[64:15];
			ang_s1 <= sprite.angle;
		end
	end

	sqvt_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en_f),
		.v_in    (v_s1),
		.ang     (ang_s1),
		.side_in (side_s1),
		.v_out   (cord_v),
		.q_out   (cord_q)
	);

	// The sequencer holds one sprite and hands out its corners in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			cnt_q <= '0;
		end else if (en_f) begin
			ser_v_q <= cord_v;
			cnt_q <= '0;
		end else if (adv && ser_v_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_f) begin
			ser_q <= cord_q;
		end
	end

	sqvt_corner u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (ser_v_q),
		.q_in   (ser_q),
		.cnt    (cnt_q),
		.proj_x (proj_x_q),
		.proj_y (proj_y_q),
		.v_out  (vertex_valid),
		.vtx    (vertex)
	);

endmodule

/* src/sqvt_checker.sv */
module sqvt_checker
	import sqvt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    sprite_ready,
	input logic    vertex_valid,
	input logic    vertex_ready,
	input vertex_t vertex
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=> vertex_valid && $stable(vertex))
		else $error("vertex request changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> (vertex.last == (vertex.corner == CORNER_LAST)))
		else $error("last flag does not match the fourth corner");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_ready && !vertex.last |=>
			vertex_valid && vertex.corner == $past(vertex.corner) + 2'd1)
		else $error("corners of a sprite are not back to back in order");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |-> !sprite_ready)
		else $error("sprite accepted while the output is stalled");

endmodule

bind sprite_quad_vertex_transform sqvt_checker u_sqvt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sprite_ready (sprite_ready),
	.vertex_valid (vertex_valid),
	.vertex_ready (vertex_ready),
	.vertex       (vertex)
);

/* tb/sqvt_checker.sv */
`timescale 1ns / 100ps
module sqvt_scoreboard
	import sqvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sprite_valid,
	input  logic        sprite_ready,
	input  sprite_t     sprite,
	input  logic        vertex_valid,
	input  logic        vertex_ready,
	input  vertex_t     vertex,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	logic signed [31:0] proj_x, proj_y;
	vertex_t corner_queue[$];

	assign pending = corner_queue.size();

	function automatic logic signed [63:0] floor_shr(input logic signed [127:0] v, input int sh);
		logic signed [127:0] r;
		r = v >>> sh;
		return r[63:0];
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	task automatic unit_circle(input logic [15:0] ang, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic signed [63:0] x, y, z, nx;
		logic [15:0] a;
		logic mirror;
		int i;
		x = 64'sd652032874;
		y = 0;
		a = ang;
		mirror = (a >= 16'h4000) && (a < 16'hC000);
		if (mirror)
			a = a ^ 16'h8000;
		z = 64'(signed'({a, 16'h0000}));
		for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - 64'(atan_turn(i));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + 64'(atan_turn(i));
			end
			x = nx;
		end
		c = mirror ? -x : x;
		s = mirror ? -y : y;
	endtask

	task automatic predict_corners(input sprite_t sp);
		logic signed [63:0] w, h, offx, offy, c, s, lx, ly, rx, ry;
		vertex_t v;
		int k;
		int sgx[4] = '{-1, 1, 1, -1};
		int sgy[4] = '{-1, -1, 1, 1};
		w = sp.width;
		h = sp.height;
		offx = floor_shr(128'(64'(sp.pivot_x) - 64'sd32768) * 128'(w), 15);
		offy = floor_shr(128'(64'(sp.pivot_y) - 64'sd32768) * 128'(h), 15);
		c = 64'sd1073741824;
		s = 0;
		if (sp.angle != 0)
			unit_circle(sp.angle, c, s);
		for (k = 0; k < 4; k++) begin
			lx = clamp32(floor_shr(128'(64'(sgx[k]) * w - offx), 1));
			ly = clamp32(floor_shr(128'(64'(sgy[k]) * h - offy), 1));
			rx = lx;
			ry = ly;
			if (sp.angle != 0) begin
				rx = clamp32(floor_shr(128'(lx) * 128'(c) - 128'(ly) * 128'(s), 30));
				ry = clamp32(floor_shr(128'(lx) * 128'(s) + 128'(ly) * 128'(c), 30));
			end
			rx = clamp32(floor_shr(128'(rx) * 128'(64'(sp.scale_x)), 16));
			ry = clamp32(floor_shr(128'(ry) * 128'(64'(sp.scale_y)), 16));
			rx = clamp32(rx + 64'(sp.position_x));
			ry = clamp32(ry + 64'(sp.position_y));
			rx = clamp32(floor_shr(128'(rx) * 128'(64'(proj_x)), 16));
			ry = clamp32(floor_shr(128'(ry) * 128'(64'(proj_y)), 16));
			v.corner = 2'(k);
			v.device_x = rx[31:0];
			v.device_y = ry[31:0];
			v.last = (k == 3);
			corner_queue.push_back(v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_x <= 32'sh40000000;
			proj_y <= 32'sh40000000;
			fail_count <= 0;
			corner_queue.delete();
		end else begin
			if (vertex_valid && vertex_ready) begin
				if (corner_queue.size() == 0) begin
					$display("%0t: unexpected vertex %h", $time, vertex);
					fail_count <= fail_count + 1;
				end else begin
					if (vertex !== corner_queue[0]) begin
						$display("%0t: vertex mismatch expected %h actual %h", $time,
							corner_queue[0], vertex);
						fail_count <= fail_count + 1;
					end
					void'(corner_queue.pop_front());
				end
			end
			if (sprite_valid && sprite_ready)
				predict_corners(sprite);
			if (cfg_we) begin
				if (cfg_index == CFG_PROJ_X)
					proj_x <= cfg_data;
				else if (cfg_index == CFG_PROJ_Y)
					proj_y <= cfg_data;
			end
		end
	end
endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
	import sqvt_pkg::*;

	logic clk = 0, arst_n = 0;
	logic sprite_valid = 0, vertex_ready = 0, cfg_we = 0;
	logic sprite_ready, vertex_valid;
	sprite_t sprite = '0;
	vertex_t vertex;
	logic [1:0] cfg_index = CFG_PROJ_X;
	logic [31:0] cfg_data = 0;
	int fail_count, pending;
	int cycles = 0;
	int hold_off = 0;
	bit stall_req = 0;
	bit stall_taken = 0;

	always #4 clk = ~clk;

	sprite_quad_vertex_transform uut (.*);
	sqvt_scoreboard chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int short_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (stall_req && !stall_taken) begin
			stall_taken <= 1;
			hold_off <= 300;
			vertex_ready <= 0;
		end else if (hold_off > 0) begin
			vertex_ready <= 0;
			hold_off <= hold_off - 1;
		end else if (cycles < 300 || cycles % 1000 < 150)
			vertex_ready <= 1;
		else
			vertex_ready <= ($urandom_range(0, 3) != 0);
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 1600000)) - 800000);
		endcase
	endfunction

	function automatic sprite_t random_sprite();
		sprite_t sp;
		sp.position_x = pick_value();
		sp.position_y = pick_value();
		sp.width = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 4000000);
		sp.height = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 4000000);
		sp.pivot_x = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 65536);
		sp.pivot_y = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 65536);
		sp.angle = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
		sp.scale_x = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 200000);
		sp.scale_y = ($urandom_range(0, 4) == 0) ? pick_value() : $urandom_range(0, 200000);
		return sp;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next request can follow with no gap.
	task automatic send_sprite(input sprite_t sp);
		int gap;
		gap = short_gap();
		if (gap > 0) begin
			sprite_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		sprite <= sp;
		sprite_valid <= 1;
		do @(posedge clk); while (!sprite_ready);
		@(negedge clk);
	endtask

	task automatic write_proj(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		sprite_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (CORDIC_STAGES + 20) @(posedge clk);
	endtask

	initial begin
		sprite_t sp;
		logic [31:0] extremes[5] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h1};
		logic [15:0] angles[10] = '{16'h0, 16'h1, 16'h3fff, 16'h4000, 16'h7fff,
			16'h8000, 16'hbfff, 16'hc000, 16'hffff, 16'h2000};
		int i;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Directed: every quadrant boundary of the angle, then field extremes.
		for (i = 0; i < 10; i++) begin
			sp = '{32'h10000, 32'h20000, 32'h40000, 32'h30000, 32'h8000, 32'h8000,
				angles[i], 32'h10000, 32'h10000};
			send_sprite(sp);
		end
		for (i = 0; i < 5; i++) begin
			sp = '{extremes[i], extremes[(i + 1) % 5], extremes[i], extremes[(i + 2) % 5],
				extremes[(i + 3) % 5], extremes[i], 16'(extremes[i]), extremes[(i + 4) % 5],
				extremes[i]};
			send_sprite(sp);
		end
		// Long receiver stall while sprites keep arriving.
		stall_req = 1;
		for (i = 0; i < 12; i++) send_sprite(random_sprite());
		drain();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin write_proj(CFG_PROJ_X, 32'h7fffffff); write_proj(CFG_PROJ_Y, 32'h80000000); end
				1: begin write_proj(CFG_PROJ_X, 32'h0); write_proj(CFG_PROJ_Y, 32'hffffffff); end
				2: begin write_proj(CFG_PROJ_X, $urandom); write_proj(CFG_PROJ_Y, $urandom); end
				3: write_proj(2'd3, $urandom);
				default: begin write_proj(CFG_PROJ_X, 32'h40000000); write_proj(CFG_PROJ_Y, 32'hc0000000); end
			endcase
			for (i = 0; i < 65; i++) send_sprite(random_sprite());
			drain();
		end
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
